// ----- hw/rtl/pattern_match_line_column_assert.svh -----
// Assertion macros shared by the pattern matcher checkers.
// Depends on a clk and an active-low rst_n in the scope of each use.
`ifndef PATTERN_MATCH_LINE_COLUMN_ASSERT_SVH
`define PATTERN_MATCH_LINE_COLUMN_ASSERT_SVH

// Property checked outside reset.
`define PMLC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every edge, reset included.
`define PMLC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/pmlc_pkg.sv -----
// Shared constants, types and helpers for the pattern matcher.
// No dependencies; every other RTL file except the assertion header refers to it by scoped names.
package pmlc_pkg;

  localparam int MAX_PATTERN  = 8;
  localparam int LINE_BITS    = 20;
  localparam int COLUMN_BITS  = 16;
  localparam int BYTE_BITS    = 8;
  localparam int PATTERN_BITS = 64;
  localparam int PLEN_BITS    = 4;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = PATTERN_BITS;
  localparam int CNT_BITS     = $clog2(MAX_PATTERN + 1);
  localparam int IDX_BITS     = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  localparam logic [BYTE_BITS-1:0] NEWLINE_BYTE = 8'h0A;

  localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_BYTES = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_LEN   = CFG_IDX_BITS'(1);

  typedef struct packed {
    logic [MAX_PATTERN-1:0][BYTE_BITS-1:0]   bytes;
    logic [MAX_PATTERN-1:0][LINE_BITS-1:0]   lines;
    logic [MAX_PATTERN-1:0][COLUMN_BITS-1:0] columns;
    logic [LINE_BITS-1:0]                    line;
    logic [COLUMN_BITS-1:0]                  column;
    logic [CNT_BITS-1:0]                     fresh;
  } win_t;

  typedef struct packed {
    logic accept;
    logic last;
  } step_t;

  typedef struct packed {
    logic                   found;
    logic [LINE_BITS-1:0]   line;
    logic [COLUMN_BITS-1:0] column;
  } hit_t;

  function automatic win_t win_reset();
    win_t w;
    w        = '0;
    w.line   = LINE_BITS'(1);
    w.column = COLUMN_BITS'(1);
    return w;
  endfunction

  // Count of window bytes taken since the last match, saturating at the window depth.
  function automatic logic [CNT_BITS-1:0] fresh_step(input logic [CNT_BITS-1:0] fresh);
    return (fresh < CNT_BITS'(MAX_PATTERN)) ? fresh + CNT_BITS'(1) : fresh;
  endfunction

endpackage

// ----- hw/rtl/pmlc_if.sv -----
// Request channels of the pattern matcher: text bytes in, match results out.
// Depends on pmlc_pkg for field widths.
interface pmlc_in_if;
  logic                           valid;
  logic                           ready;
  logic [pmlc_pkg::BYTE_BITS-1:0] text_byte;
  logic                           text_end;

  modport source (output valid, output text_byte, output text_end, input ready);
  modport sink   (input valid, input text_byte, input text_end, output ready);
endinterface

interface pmlc_out_if;
  logic                             valid;
  logic                             ready;
  logic                             match_found;
  logic [pmlc_pkg::LINE_BITS-1:0]   match_line;
  logic [pmlc_pkg::COLUMN_BITS-1:0] match_column;
  logic                             text_done;

  modport source (output valid, output match_found, output match_line,
                  output match_column, output text_done, input ready);
  modport sink   (input valid, input match_found, input match_line,
                  input match_column, input text_done, output ready);
endinterface

// ----- hw/rtl/pmlc_cfg_regs.sv -----
// Configuration registers: pattern bytes and pattern length.
// Depends on pmlc_pkg; hands out the clamped length in use.
module pmlc_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [pmlc_pkg::CFG_IDX_BITS-1:0]   cfg_idx,
  input  logic [pmlc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output logic [pmlc_pkg::PATTERN_BITS-1:0]   pattern,
  output logic [pmlc_pkg::CNT_BITS-1:0]       eff_len
);

  logic [pmlc_pkg::PATTERN_BITS-1:0] pattern_r, pattern_nxt;
  logic [pmlc_pkg::PLEN_BITS-1:0]    plen_r, plen_nxt;

  always_comb begin
    pattern_nxt = pattern_r;
    plen_nxt    = plen_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        pmlc_pkg::REG_PATTERN_BYTES: pattern_nxt = cfg_data[pmlc_pkg::PATTERN_BITS-1:0];
        pmlc_pkg::REG_PATTERN_LEN:   plen_nxt    = cfg_data[pmlc_pkg::PLEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      plen_r    <= pmlc_pkg::PLEN_BITS'(1);
    end else begin
      pattern_r <= pattern_nxt;
      plen_r    <= plen_nxt;
    end
  end

  // Zero counts as one byte, anything above the window depth as the full window.
  always_comb begin
    if (plen_r == '0) begin
      eff_len = pmlc_pkg::CNT_BITS'(1);
    end else if (plen_r > pmlc_pkg::PLEN_BITS'(pmlc_pkg::MAX_PATTERN)) begin
      eff_len = pmlc_pkg::CNT_BITS'(pmlc_pkg::MAX_PATTERN);
    end else begin
      eff_len = pmlc_pkg::CNT_BITS'(plen_r);
    end
  end

  assign pattern = pattern_r;

endmodule

// ----- hw/rtl/pmlc_window.sv -----
// Sliding window of recent text bytes with their line and column, plus position counters.
// Depends on pmlc_pkg.
module pmlc_window (
  input  logic                           clk,
  input  logic                           rst_n,
  input  pmlc_pkg::step_t                step,
  input  logic [pmlc_pkg::BYTE_BITS-1:0] text_byte,
  input  logic                           found,
  output pmlc_pkg::win_t                 win
);

  pmlc_pkg::win_t win_r, win_nxt;

  always_comb begin
    win_nxt = win_r;
    if (step.accept) begin
      if (step.last) begin
        win_nxt = pmlc_pkg::win_reset();
      end else begin
        for (int j = 1; j < pmlc_pkg::MAX_PATTERN; j++) begin
          win_nxt.bytes[j]   = win_r.bytes[j-1];
          win_nxt.lines[j]   = win_r.lines[j-1];
          win_nxt.columns[j] = win_r.columns[j-1];
        end
        win_nxt.bytes[0]   = text_byte;
        win_nxt.lines[0]   = win_r.line;
        win_nxt.columns[0] = win_r.column;
        // Newline ends its line; next byte lands at column 1. Counters saturate.
        if (text_byte == pmlc_pkg::NEWLINE_BYTE) begin
          if (win_r.line != '1) win_nxt.line = win_r.line + pmlc_pkg::LINE_BITS'(1);
          win_nxt.column = pmlc_pkg::COLUMN_BITS'(1);
        end else if (win_r.column != '1) begin
          win_nxt.column = win_r.column + pmlc_pkg::COLUMN_BITS'(1);
        end
        win_nxt.fresh = found ? '0 : pmlc_pkg::fresh_step(win_r.fresh);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= pmlc_pkg::win_reset();
    end else begin
      win_r <= win_nxt;
    end
  end

  assign win = win_r;

endmodule

// ----- hw/rtl/pmlc_compare.sv -----
// Window compare: checks the newest bytes, incoming byte included, against the pattern.
// Depends on pmlc_pkg; purely combinational.
module pmlc_compare (
  input  pmlc_pkg::win_t                    win,
  input  logic [pmlc_pkg::BYTE_BITS-1:0]    text_byte,
  input  logic [pmlc_pkg::PATTERN_BITS-1:0] pattern,
  input  logic [pmlc_pkg::CNT_BITS-1:0]     eff_len,
  output pmlc_pkg::hit_t                    hit
);

  logic [pmlc_pkg::BYTE_BITS-1:0]   sh_bytes [pmlc_pkg::MAX_PATTERN];
  logic [pmlc_pkg::LINE_BITS-1:0]   sh_lines [pmlc_pkg::MAX_PATTERN];
  logic [pmlc_pkg::COLUMN_BITS-1:0] sh_cols  [pmlc_pkg::MAX_PATTERN];
  logic [pmlc_pkg::BYTE_BITS-1:0]   pat      [pmlc_pkg::MAX_PATTERN];
  logic [pmlc_pkg::MAX_PATTERN-1:0] eq;
  logic [pmlc_pkg::CNT_BITS-1:0]    pidx;
  logic [pmlc_pkg::CNT_BITS-1:0]    start_sel;
  logic [pmlc_pkg::CNT_BITS-1:0]    fresh_inc;
  logic                             match;

  // Window as it stands once the incoming byte is shifted in.
  always_comb begin
    sh_bytes[0] = text_byte;
    sh_lines[0] = win.line;
    sh_cols[0]  = win.column;
    for (int j = 1; j < pmlc_pkg::MAX_PATTERN; j++) begin
      sh_bytes[j] = win.bytes[j-1];
      sh_lines[j] = win.lines[j-1];
      sh_cols[j]  = win.columns[j-1];
    end
    for (int k = 0; k < pmlc_pkg::MAX_PATTERN; k++) begin
      pat[k] = pattern[pmlc_pkg::BYTE_BITS*k +: pmlc_pkg::BYTE_BITS];
    end
  end

  // Window slot j holds pattern byte len-1-j; slots past the length always agree.
  always_comb begin
    pidx = '0;
    for (int j = 0; j < pmlc_pkg::MAX_PATTERN; j++) begin
      pidx  = eff_len - pmlc_pkg::CNT_BITS'(1) - pmlc_pkg::CNT_BITS'(j);
      eq[j] = (pmlc_pkg::CNT_BITS'(j) >= eff_len) ||
              (sh_bytes[j] == pat[pidx[pmlc_pkg::IDX_BITS-1:0]]);
    end
  end

  assign fresh_inc = pmlc_pkg::fresh_step(win.fresh);
  assign match     = (fresh_inc >= eff_len) && (&eq);
  assign start_sel = eff_len - pmlc_pkg::CNT_BITS'(1);

  always_comb begin
    hit.found  = match;
    hit.line   = match ? sh_lines[start_sel[pmlc_pkg::IDX_BITS-1:0]] : '0;
    hit.column = match ? sh_cols[start_sel[pmlc_pkg::IDX_BITS-1:0]]  : '0;
  end

endmodule

// ----- hw/rtl/pmlc_out_stage.sv -----
// Result register between the matcher and the result channel.
// Depends on pmlc_pkg and pmlc_out_if.
module pmlc_out_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  pmlc_pkg::step_t step,
  input  pmlc_pkg::hit_t  hit,
  output logic            can_take,
  pmlc_out_if.source      out_req
);

  logic           valid_r, valid_nxt;
  pmlc_pkg::hit_t hit_r, hit_nxt;
  logic           done_r, done_nxt;
  logic           has_result;

  assign has_result = hit.found || step.last;
  assign can_take   = !valid_r || out_req.ready;

  always_comb begin
    valid_nxt = valid_r;
    hit_nxt   = hit_r;
    done_nxt  = done_r;
    if (step.accept && has_result) begin
      valid_nxt = 1'b1;
      hit_nxt   = hit;
      done_nxt  = step.last;
    end else if (out_req.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_r  <= hit_nxt;
    done_r <= done_nxt;
  end

  assign out_req.valid        = valid_r;
  assign out_req.match_found  = hit_r.found;
  assign out_req.match_line   = hit_r.line;
  assign out_req.match_column = hit_r.column;
  assign out_req.text_done    = done_r;

endmodule

// ----- hw/rtl/pattern_match_line_column.sv -----
// Streaming pattern matcher: top level.
// Depends on pmlc_pkg, pmlc_if and the pmlc_* submodules.
//
// Takes one text byte per request on in_req and reports where a configured
// pattern of 1 to 8 bytes occurs, as the 1-based line and column of the
// match's first byte. Matches never overlap: after a hit, every byte of the
// next match must arrive after it. A newline belongs to the end of its line;
// the byte that follows it sits at column 1 of the next line. Line and column
// saturate at their all-ones values. A byte flagged text_end is searched like
// any other, always yields a result with text_done set (with the match, if it
// completes one), and returns the window and counters to their start values.
// Bytes that neither complete a match nor close a text yield no result.
// Rate: one byte per clock unless the result side stalls. The full 8-byte
// window is compared with the pattern combinationally, between the window
// registers and the result register, so a result appears on out_req in the
// cycle after its byte is taken. The single result register decouples the two
// sides: in_req.ready stays high while that register is empty or is being
// drained in the same cycle. Write pattern_bytes (index 0, first byte in the
// low 8 bits) and pattern_len (index 1, 0 acts as 1, above 8 acts as 8) on
// the cfg port only while no text is in flight. No clearing pass after reset.
module pattern_match_line_column (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [pmlc_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [pmlc_pkg::CFG_DATA_BITS-1:0] cfg_data,
  pmlc_in_if.sink                            in_req,
  pmlc_out_if.source                         out_req
);

  logic [pmlc_pkg::PATTERN_BITS-1:0] pattern;
  logic [pmlc_pkg::CNT_BITS-1:0]     eff_len;
  pmlc_pkg::win_t                    win;
  pmlc_pkg::hit_t                    hit;
  pmlc_pkg::step_t                   step;
  logic                              can_take;

  // A request is taken whenever the result register has room for its answer.
  assign in_req.ready = can_take;
  assign step.accept  = in_req.valid && can_take;
  assign step.last    = in_req.text_end;

  pmlc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .pattern  (pattern),
    .eff_len  (eff_len)
  );

  // Hold recent bytes and their positions; advance on each accepted request.
  pmlc_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .text_byte (in_req.text_byte),
    .found     (hit.found),
    .win       (win)
  );

  // Compare the window, incoming byte included, against the pattern.
  pmlc_compare u_compare (
    .win       (win),
    .text_byte (in_req.text_byte),
    .pattern   (pattern),
    .eff_len   (eff_len),
    .hit       (hit)
  );

  // Register the result; drop requests that produce nothing.
  pmlc_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .hit      (hit),
    .can_take (can_take),
    .out_req  (out_req)
  );

endmodule

// ----- hw/rtl/pmlc_checker.sv -----
// Port-level checks for the pattern matcher, bound to the top level.
// Depends on pmlc_pkg and pattern_match_line_column_assert.svh.
`include "pattern_match_line_column_assert.svh"

module pmlc_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             out_match_found,
  input logic [pmlc_pkg::LINE_BITS-1:0]   out_match_line,
  input logic [pmlc_pkg::COLUMN_BITS-1:0] out_match_column,
  input logic                             out_text_done
);

  `PMLC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_match_line) && $stable(out_match_column) && $stable(out_match_found) && $stable(out_text_done), "stalled result changed")
  `PMLC_ASSERT(a_no_empty, out_valid |-> out_match_found || out_text_done, "result carries neither match nor text end")
  `PMLC_ASSERT(a_pos_zero, out_valid && !out_match_found |-> out_match_line == '0 && out_match_column == '0, "position set without match")
  `PMLC_ASSERT(a_pos_set, out_valid && out_match_found |-> out_match_line != '0 && out_match_column != '0, "match at position zero")
  `PMLC_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> !out_valid && in_ready, "result pending after reset")

endmodule

bind pattern_match_line_column pmlc_checker u_pmlc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_req.valid),
  .in_ready         (in_req.ready),
  .out_valid        (out_req.valid),
  .out_ready        (out_req.ready),
  .out_match_found  (out_req.match_found),
  .out_match_line   (out_req.match_line),
  .out_match_column (out_req.match_column),
  .out_text_done    (out_req.text_done)
);

// ----- tb/sv/pmlc_tb_pkg.sv -----
`timescale 1ns / 100ps
// Match tracker for the pattern matcher testbench: predicts results from
// accepted text bytes and checks the results the block returns.
// Depends on pmlc_pkg for field widths and register indexes.
package pmlc_tb_pkg;
  import pmlc_pkg::*;

  typedef struct {
    bit                   found;
    bit [LINE_BITS-1:0]   line;
    bit [COLUMN_BITS-1:0] column;
    bit                   done;
  } match_rec_t;

  class match_tracker;
    bit [PATTERN_BITS-1:0] pattern;
    bit [PLEN_BITS-1:0]    plen;
    bit [BYTE_BITS-1:0]    win_byte [MAX_PATTERN];
    bit [LINE_BITS-1:0]    win_line [MAX_PATTERN];
    bit [COLUMN_BITS-1:0]  win_col  [MAX_PATTERN];
    bit [LINE_BITS-1:0]    cur_line;
    bit [COLUMN_BITS-1:0]  cur_col;
    int                    fresh;
    match_rec_t            expected_matches [$];
    int                    errors;

    function new();
      pattern = '0;
      plen    = PLEN_BITS'(1);
      errors  = 0;
      restart_text();
    endfunction

    function void restart_text();
      for (int i = 0; i < MAX_PATTERN; i++) begin
        win_byte[i] = '0;
        win_line[i] = '0;
        win_col[i]  = '0;
      end
      cur_line = LINE_BITS'(1);
      cur_col  = COLUMN_BITS'(1);
      fresh    = 0;
    endfunction

    function void write_reg(input bit [CFG_IDX_BITS-1:0] idx,
                            input bit [CFG_DATA_BITS-1:0] data);
      if (idx == REG_PATTERN_BYTES) pattern = data;
      else if (idx == REG_PATTERN_LEN) plen = data[PLEN_BITS-1:0];
    endfunction

    function void note_text_byte(input bit [BYTE_BITS-1:0] b, input bit last);
      int         n;
      bit         hit;
      match_rec_t r;
      n = (plen == 0) ? 1 : (plen > MAX_PATTERN) ? MAX_PATTERN : int'(plen);
      for (int i = MAX_PATTERN - 1; i > 0; i--) begin
        win_byte[i] = win_byte[i-1];
        win_line[i] = win_line[i-1];
        win_col[i]  = win_col[i-1];
      end
      win_byte[0] = b;
      win_line[0] = cur_line;
      win_col[0]  = cur_col;
      if (fresh < MAX_PATTERN) fresh++;
      hit = (fresh >= n);
      for (int k = 0; k < n; k++)
        if (win_byte[n-1-k] != pattern[8*k +: 8]) hit = 1'b0;
      r.found  = hit;
      r.line   = hit ? win_line[n-1] : '0;
      r.column = hit ? win_col[n-1] : '0;
      r.done   = last;
      if (hit) fresh = 0;
      if (b == NEWLINE_BYTE) begin
        if (cur_line != '1) cur_line++;
        cur_col = COLUMN_BITS'(1);
      end else if (cur_col != '1) begin
        cur_col++;
      end
      if (hit || last) expected_matches.push_back(r);
      if (last) restart_text();
    endfunction

    task report(input string what, input longint unsigned want, input longint unsigned got);
      errors++;
      if (errors <= 50)
        $display("%0t mismatch %s: expected %0d, got %0d", $time, what, want, got);
    endtask

    task check_match(input match_rec_t got);
      match_rec_t want;
      if (expected_matches.size() == 0) begin
        report("result with nothing pending", 0, 1);
        return;
      end
      want = expected_matches.pop_front();
      if (got.found != want.found) report("match_found", want.found, got.found);
      if (got.line != want.line) report("match_line", want.line, got.line);
      if (got.column != want.column) report("match_column", want.column, got.column);
      if (got.done != want.done) report("text_done", want.done, got.done);
    endtask

    task close_out();
      if (expected_matches.size() != 0)
        report("results never returned", 0, expected_matches.size());
    endtask
  endclass

endpackage

// ----- tb/sv/pattern_match_line_column_tb.sv -----
`timescale 1ns / 100ps
// Top of the pattern matcher testbench: drives text bytes and register writes,
// stalls the result side, and checks every result through pmlc_tb_pkg.
// Depends on pmlc_pkg, pmlc_if, pmlc_tb_pkg and pattern_match_line_column.
module pattern_match_line_column_tb;
  import pmlc_pkg::*;
  import pmlc_tb_pkg::*;

  localparam int     CLK_HALF      = 4;
  localparam int     RESET_CYCLES  = 11;
  // Settle time after the last result, to cover anything still moving.
  localparam int     SETTLE_CYCLES = 4;
  localparam longint CYCLE_LIMIT   = 2_000_000;
  localparam int     RANDOM_ITEMS  = 1550;
  localparam int     PHASE_ITEMS   = 130;

  // Indexes with no register behind them; writes there must change nothing.
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_A = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_B = CFG_IDX_BITS'(3);

  localparam logic [BYTE_BITS-1:0] CHAR_A = 8'h61;
  localparam logic [BYTE_BITS-1:0] CHAR_B = 8'h62;
  localparam logic [BYTE_BITS-1:0] CHAR_C = 8'h63;
  localparam logic [BYTE_BITS-1:0] CHAR_X = 8'h78;
  localparam logic [BYTE_BITS-1:0] CHAR_Y = 8'h79;
  localparam logic [BYTE_BITS-1:0] CHAR_Z = 8'h7A;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_idx;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  pmlc_in_if  in_req();
  pmlc_out_if out_req();

  pattern_match_line_column dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_req   (in_req),
    .out_req  (out_req)
  );

  match_tracker tracker = new();

  longint             cycles = 0;
  int                 burst_left = 0;
  int                 gap_max = 0;
  int                 sent = 0;
  bit [BYTE_BITS-1:0] text_q [$];

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Watchdog: end the run if it has stopped making progress.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("pattern_match_line_column_tb: errors");
      $finish;
    end
  end

  // Result side: switch between stall styles, each held for a random span, so
  // stalls land on every phase of the work, including long fully-ready runs.
  initial begin
    int span;
    int mode;
    span = 0;
    mode = 0;
    out_req.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(100, 400);
      end
      span--;
      case (mode)
        0: begin
          out_req.ready <= 1'b1;
        end
        1: begin
          out_req.ready <= ($urandom_range(0, 3) != 0);
        end
        2: begin
          out_req.ready <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          out_req.ready <= ((span % 16) >= 12);
        end
      endcase
    end
  end

  // Check each accepted result against the oldest pending prediction.
  // Values read here are the ones that held at the edge.
  always @(posedge clk) begin : result_check
    match_rec_t got;
    if (rst_n && out_req.valid && out_req.ready) begin
      got.found  = out_req.match_found;
      got.line   = out_req.match_line;
      got.column = out_req.match_column;
      got.done   = out_req.text_done;
      tracker.check_match(got);
    end
  end

  // Offer one text byte and hold it until the block takes the request.
  // Between bursts, drop valid for a random gap (none when gap_max is 0).
  task automatic send_byte(input bit [BYTE_BITS-1:0] b, input bit last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gap_max > 0) begin
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
          in_req.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    burst_left--;
    in_req.valid     <= 1'b1;
    in_req.text_byte <= b;
    in_req.text_end  <= last;
    do @(posedge clk); while (!in_req.ready);
    tracker.note_text_byte(b, last);
    sent++;
  endtask

  // Send the queued text, flagging its final byte as the end of the text.
  task automatic send_text();
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  // Hold off new requests until every predicted result has come back,
  // then let the pipeline settle.
  task automatic drain();
    in_req.valid <= 1'b0;
    while (tracker.expected_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    tracker.write_reg(idx, data);
  endtask

  // Reprogram the pattern while the block is idle and between texts.
  // The length write carries random upper bits, which the block must drop;
  // one spare index gets random data as well.
  task automatic configure(input bit [PATTERN_BITS-1:0] pat, input bit [PLEN_BITS-1:0] len);
    logic [CFG_DATA_BITS-1:0] len_word;
    drain();
    len_word = {$urandom, $urandom};
    len_word[PLEN_BITS-1:0] = len;
    cfg_write(REG_PATTERN_BYTES, pat);
    cfg_write(REG_PATTERN_LEN, len_word);
    cfg_write($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, {$urandom, $urandom});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Build a random text that is mostly whole or cut-short copies of the
  // pattern, mixed with newlines, pattern bytes and arbitrary bytes.
  function automatic void build_text(input int n_eff, input bit [PATTERN_BITS-1:0] pat);
    int target;
    int pick;
    int cut;
    target = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 48);
    while (text_q.size() < target) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        for (int k = 0; k < n_eff; k++) text_q.push_back(pat[8*k +: 8]);
      end else if (pick < 6) begin
        cut = $urandom_range(1, n_eff);
        for (int k = 0; k < cut; k++) text_q.push_back(pat[8*k +: 8]);
      end else if (pick == 6) begin
        text_q.push_back(NEWLINE_BYTE);
      end else if (pick == 7) begin
        text_q.push_back(BYTE_BITS'($urandom_range(0, 255)));
      end else begin
        text_q.push_back(pat[8*$urandom_range(0, n_eff - 1) +: 8]);
      end
    end
  endfunction

  initial begin
    bit [PATTERN_BITS-1:0] pat;
    bit [PLEN_BITS-1:0]    len;
    bit [BYTE_BITS-1:0]    alpha_a;
    bit [BYTE_BITS-1:0]    alpha_b;
    int                    n_eff;
    int                    phase;
    int                    phase_start;

    rst_n            <= 1'b0;
    in_req.valid     <= 1'b0;
    in_req.text_byte <= '0;
    in_req.text_end  <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_idx          <= '0;
    cfg_data         <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset pattern: a single zero byte. Zero bytes match; all-ones does not.
    gap_max = 3;
    text_q = '{8'h00, 8'hFF, NEWLINE_BYTE, 8'h00};
    send_text();

    // Repeated-letter pattern: matches must not overlap, and the closing
    // newline ends the text without a match.
    configure({48'h0, CHAR_A, CHAR_A}, PLEN_BITS'(2));
    text_q = '{CHAR_A, CHAR_A, CHAR_A, CHAR_A, CHAR_A, NEWLINE_BYTE};
    send_text();

    // Pattern spanning a newline, completed by the closing byte.
    configure({40'h0, CHAR_C, NEWLINE_BYTE, CHAR_B}, PLEN_BITS'(3));
    text_q = '{CHAR_X, CHAR_B, NEWLINE_BYTE, CHAR_C};
    send_text();

    // All-ones pattern with an oversized length code, which acts as eight.
    configure('1, '1);
    repeat (8) text_q.push_back(8'hFF);
    send_text();

    // The same pattern on two lines, sent back to back: each copy reports
    // its own line, both at column 1.
    configure({40'h0, CHAR_Z, CHAR_Y, CHAR_X}, PLEN_BITS'(3));
    gap_max = 0;
    text_q = '{CHAR_X, CHAR_Y, CHAR_Z, NEWLINE_BYTE, CHAR_X, CHAR_Y, CHAR_Z};
    send_text();

    // Random phases: a new pattern per phase, the first ones at the length
    // extremes, then random texts until the phase has its share of bytes.
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase)
        0: len = PLEN_BITS'(MAX_PATTERN);
        1: len = PLEN_BITS'(1);
        2: len = '0;
        3: len = '1;
        default: len = PLEN_BITS'($urandom_range(0, 15));
      endcase
      n_eff = (len == 0) ? 1 : (len > MAX_PATTERN) ? MAX_PATTERN : int'(len);
      if ($urandom_range(0, 1)) begin
        pat = {$urandom, $urandom};
      end else begin
        // Two-letter alphabet: self-overlapping patterns, now and then a newline.
        alpha_a = BYTE_BITS'($urandom_range(0, 255));
        alpha_b = $urandom_range(0, 3) == 0 ? NEWLINE_BYTE : BYTE_BITS'($urandom_range(0, 255));
        for (int k = 0; k < MAX_PATTERN; k++)
          pat[8*k +: 8] = $urandom_range(0, 1) ? alpha_a : alpha_b;
      end
      configure(pat, len);
      gap_max = (phase % 4 == 1) ? 0 : $urandom_range(1, 10);
      phase_start = sent;
      while (sent - phase_start < PHASE_ITEMS) begin
        build_text(n_eff, pat);
        send_text();
      end
      phase++;
    end

    drain();
    tracker.close_out();
    if (tracker.errors == 0) begin
      $display("pattern_match_line_column_tb: clean");
    end else begin
      $display("pattern_match_line_column_tb: errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/pmlc_pkg.sv
hw/rtl/pmlc_if.sv
hw/rtl/pmlc_cfg_regs.sv
hw/rtl/pmlc_window.sv
hw/rtl/pmlc_compare.sv
hw/rtl/pmlc_out_stage.sv
hw/rtl/pattern_match_line_column.sv
hw/rtl/pmlc_checker.sv
tb/sv/pmlc_tb_pkg.sv
tb/sv/pattern_match_line_column_tb.sv
